### rtl/axis_angle_rotation_matrix_macros.svh
// Assertion macros shared by the rotation matrix RTL.
// No dependencies.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
// implication checked every clock outside reset
`define AARM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the next clock
`define AARM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/aarm_pkg.sv
// Package for the axis-angle rotation matrix: widths, constants, CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package aarm_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 14;
    localparam int TAB_LEN      = 24;
    localparam int N_STEPS      = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    // width of a cell's step index
    localparam int STEP_W       = (N_STEPS > 1) ? $clog2(N_STEPS) : 1;
    localparam int AXIS_W       = FRAC_BITS + 2;
    localparam int OUT_W        = FRAC_BITS + 4;
    localparam int VEC_FRAC     = 30;
    localparam int VEC_W        = 33;
    localparam int ANG_W        = 26;
    localparam int TURN_IN      = 92160;
    localparam int DEG90        = 5898240;
    localparam int DEG180       = 11796480;
    localparam int DEG360       = 23592960;
    localparam int GAIN_START   = 652032874;
    localparam int SC_W         = FRAC_BITS + 3;
    localparam int PROD_W       = 2 * FRAC_BITS + 12;
    // scaled axis products and the sums are carried in this width
    localparam int SUM_W        = 2 * FRAC_BITS + 10;

    // one CORDIC cell's payload
    typedef struct packed {
        logic                    vld;
        logic                    flip;
        logic signed [ANG_W-1:0] t;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
    } t_cell;

    function automatic logic signed [ANG_W-1:0] atan_at(input int idx);
        logic signed [ANG_W-1:0] tab [0:TAB_LEN-1];
        tab = '{26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
                26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667,
                26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
                26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0};
        return tab[idx];
    endfunction
endpackage

### rtl/aarm_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation and a register.
// Depends on aarm_pkg; the step index arrives on a port tied to a constant.
`timescale 1ns / 1ps
module aarm_cell
    import aarm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [STEP_W-1:0] i_step,
    input  t_cell             i_cell,
    output t_cell             o_cell
);
    t_cell r_cell, n_cell;

    // rotate toward zero residual angle
    always_comb begin
        n_cell = i_cell;
        if (i_cell.t >= 0) begin
            n_cell.x = i_cell.x - (i_cell.y >>> i_step);
            n_cell.y = i_cell.y + (i_cell.x >>> i_step);
            n_cell.t = i_cell.t - atan_at(int'(i_step));
        end else begin
            n_cell.x = i_cell.x + (i_cell.y >>> i_step);
            n_cell.y = i_cell.y - (i_cell.x >>> i_step);
            n_cell.t = i_cell.t + atan_at(int'(i_step));
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end
    end

    assign o_cell = r_cell;
endmodule

### rtl/aarm_matrix.sv
// Matrix back end: rounds sine/cosine, forms axis products and the nine entries.
// Depends on aarm_pkg.
`timescale 1ns / 1ps
module aarm_matrix
    import aarm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell                    i_cell,
    output logic                     o_vld,
    output logic signed [OUT_W-1:0]  o_ent [9]
);
    localparam int SH = VEC_FRAC - FRAC_BITS;

    // stage 1: sin/cos rounding, axis products
    logic                       r_v1;
    logic signed [SC_W-1:0]     r_cs, r_sn, r_a;
    logic signed [AXIS_W-1:0]   r_ax, r_ay, r_az;
    logic signed [2*AXIS_W-1:0] r_p [6];
    logic signed [VEC_W-1:0]    n_xf, n_yf;
    logic signed [VEC_W-1:0]    n_xr, n_yr;
    logic signed [SC_W-1:0]     n_cs;

    always_comb begin
        n_xf = i_cell.flip ? -i_cell.x : i_cell.x;
        n_yf = i_cell.flip ? -i_cell.y : i_cell.y;
        n_xr = (n_xf + (VEC_W'(1) <<< (SH - 1))) >>> SH;
        n_yr = (n_yf + (VEC_W'(1) <<< (SH - 1))) >>> SH;
        n_cs = SC_W'(n_xr);
    end

    always_ff @(posedge i_clk) begin
        r_v1 <= i_cell.vld;
        r_cs <= n_cs;
        r_sn <= SC_W'(n_yr);
        r_a  <= SC_W'(1 << FRAC_BITS) - n_cs;
        r_ax <= i_cell.ax;
        r_ay <= i_cell.ay;
        r_az <= i_cell.az;
        r_p[0] <= i_cell.ax * i_cell.ax;
        r_p[1] <= i_cell.ay * i_cell.ay;
        r_p[2] <= i_cell.az * i_cell.az;
        r_p[3] <= i_cell.ax * i_cell.ay;
        r_p[4] <= i_cell.ax * i_cell.az;
        r_p[5] <= i_cell.ay * i_cell.az;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end
    end

    // stage 2: rounded products times a, cos and axis times sin
    logic                    r_v2;
    logic signed [SUM_W-1:0] r_pa [6];
    logic signed [SUM_W-1:0] r_cone;
    logic signed [SUM_W-1:0] r_xs, r_ys, r_zs;
    logic signed [2*AXIS_W-1:0] n_pr [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_pr[k] = (r_p[k] + (2*AXIS_W)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
    end

    // operands widened first so the products cannot wrap
    always_ff @(posedge i_clk) begin
        r_v2 <= r_v1;
        for (int k = 0; k < 6; k++) begin
            r_pa[k] <= SUM_W'(n_pr[k]) * SUM_W'(r_a);
        end
        r_cone <= SUM_W'(r_cs) <<< FRAC_BITS;
        r_xs <= SUM_W'(r_ax) * SUM_W'(r_sn);
        r_ys <= SUM_W'(r_ay) * SUM_W'(r_sn);
        r_zs <= SUM_W'(r_az) * SUM_W'(r_sn);
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end
    end

    // stage 3: sums, rounding, saturation
    logic                    r_v3;
    logic signed [OUT_W-1:0] r_ent [9];
    logic signed [SUM_W-1:0] n_sum [9];
    logic signed [SUM_W-1:0] n_rs  [9];

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'((1 << (OUT_W - 1)) - 1)) begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end else if (v < -SUM_W'(1 << (OUT_W - 1))) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end
        return OUT_W'(v);
    endfunction

    always_comb begin
        n_sum[0] = r_cone + r_pa[0];
        n_sum[1] = r_pa[3] + r_zs;
        n_sum[2] = r_pa[4] - r_ys;
        n_sum[3] = r_pa[3] - r_zs;
        n_sum[4] = r_cone + r_pa[1];
        n_sum[5] = r_pa[5] + r_xs;
        n_sum[6] = r_pa[4] + r_ys;
        n_sum[7] = r_pa[5] - r_xs;
        n_sum[8] = r_cone + r_pa[2];
        for (int k = 0; k < 9; k++) begin
            n_rs[k] = (n_sum[k] + SUM_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v3 <= r_v2;
        for (int k = 0; k < 9; k++) begin
            r_ent[k] <= sat(n_rs[k]);
        end
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end
    end

    assign o_vld = r_v3;
    assign o_ent = r_ent;
endmodule

### rtl/axis_angle_rotation_matrix.sv
// Axis-angle rotation matrix top level: angle fold, CORDIC cell chain, matrix back end.
// Depends on aarm_pkg, aarm_cell, aarm_matrix and the macros header.
// Usage:
//   Drive i_angle_deg (degrees, 8 fraction bits) and the Q2.14 axis with start.
//   busy is always low: one item is accepted in every cycle.
//   Stages: two for the modulo-360 reduction and fold, one per CORDIC
//   cell (CORDIC_STEPS cells), three for products, sums and saturation.
//   Throughput is one item a cycle, set by the chain of CORDIC cells,
//   each handing its vector on every clock.
//   o_valid strobes for one cycle with the nine Q4.14 entries, column-major.
//   The receiver cannot stall; results are shown once and move on.
//   Synchronous reset clears all valid flags; items in flight are dropped.
//   The modulo-360 reduction uses a reciprocal multiply split over two stages.
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_macros.svh"
module axis_angle_rotation_matrix
    import aarm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [31:0]       i_angle_deg,
    input  logic signed [AXIS_W-1:0] i_axis_x,
    input  logic signed [AXIS_W-1:0] i_axis_y,
    input  logic signed [AXIS_W-1:0] i_axis_z,
    output logic                     o_valid,
    output logic signed [OUT_W-1:0]  o_c0_r0,
    output logic signed [OUT_W-1:0]  o_c0_r1,
    output logic signed [OUT_W-1:0]  o_c0_r2,
    output logic signed [OUT_W-1:0]  o_c1_r0,
    output logic signed [OUT_W-1:0]  o_c1_r1,
    output logic signed [OUT_W-1:0]  o_c1_r2,
    output logic signed [OUT_W-1:0]  o_c2_r0,
    output logic signed [OUT_W-1:0]  o_c2_r1,
    output logic signed [OUT_W-1:0]  o_c2_r2
);
    assign busy = 1'b0;

    // reduce stage A: bias to unsigned, quotient estimate by reciprocal (2^48/92160)
    localparam longint RECIP = (64'sd1 <<< 48) / TURN_IN + 1;
    logic              r_va;
    logic [32:0]       r_ua;
    logic [31:0]       r_qa;
    logic signed [AXIS_W-1:0] r_axa, r_aya, r_aza;
    logic [32:0]       n_u;
    logic [81:0]       n_qp;

    always_comb begin
        // adding 2^31 keeps it unsigned; the offset 2^31 mod TURN_IN is removed later
        n_u  = 33'(i_angle_deg) + 33'h0_8000_0000;
        n_qp = 82'(n_u) * 82'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        r_va  <= start;
        r_ua  <= n_u;
        r_qa  <= 32'(n_qp >> 48);
        r_axa <= i_axis_x;
        r_aya <= i_axis_y;
        r_aza <= i_axis_z;
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end
    end

    // reduce stage B: remainder, undo bias, fold to [-90, 90]
    localparam int BIAS_R = 32'h8000_0000 % TURN_IN;
    t_cell             r_c0;
    logic signed [34:0] n_r0;
    logic signed [34:0] n_r;
    logic signed [ANG_W+1:0] n_t;
    logic              n_flip;

    always_comb begin
        n_r0 = 35'(r_ua) - 35'(r_qa) * 35'(TURN_IN);
        if (n_r0 < 0) begin
            n_r0 = n_r0 + 35'(TURN_IN);
        end
        if (n_r0 >= 35'(TURN_IN)) begin
            n_r0 = n_r0 - 35'(TURN_IN);
        end
        n_r = n_r0 - 35'(BIAS_R);
        if (n_r < 0) begin
            n_r = n_r + 35'(TURN_IN);
        end
        n_t = (ANG_W+2)'(n_r) <<< 8;
        if (n_t > (ANG_W+2)'(DEG180)) begin
            n_t = n_t - (ANG_W+2)'(DEG360);
        end
        n_flip = 1'b0;
        if (n_t > (ANG_W+2)'(DEG90)) begin
            n_t    = n_t - (ANG_W+2)'(DEG180);
            n_flip = 1'b1;
        end else if (n_t < -(ANG_W+2)'(DEG90)) begin
            n_t    = n_t + (ANG_W+2)'(DEG180);
            n_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0.vld  <= r_va;
        r_c0.flip <= n_flip;
        r_c0.t    <= ANG_W'(n_t);
        r_c0.x    <= VEC_W'(GAIN_START);
        r_c0.y    <= '0;
        r_c0.ax   <= r_axa;
        r_c0.ay   <= r_aya;
        r_c0.az   <= r_aza;
        if (!i_rst_n) begin
            r_c0.vld <= 1'b0;
        end
    end

    // chain of CORDIC cells
    t_cell w_chain [N_STEPS+1];
    assign w_chain[0] = r_c0;

    for (genvar g = 0; g < N_STEPS; g++) begin : g_cell
        aarm_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_step (STEP_W'(g)),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    logic signed [OUT_W-1:0] w_ent [9];

    aarm_matrix u_matrix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cell (w_chain[N_STEPS]),
        .o_vld  (o_valid),
        .o_ent  (w_ent)
    );

    assign o_c0_r0 = w_ent[0];
    assign o_c0_r1 = w_ent[1];
    assign o_c0_r2 = w_ent[2];
    assign o_c1_r0 = w_ent[3];
    assign o_c1_r1 = w_ent[4];
    assign o_c1_r2 = w_ent[5];
    assign o_c2_r0 = w_ent[6];
    assign o_c2_r1 = w_ent[7];
    assign o_c2_r2 = w_ent[8];

    `AARM_ASSERT_NXT(a_start_enters, i_clk, i_rst_n, start, r_va)
    `AARM_ASSERT_IMP(a_fold_range, i_clk, i_rst_n, r_c0.vld,
        (r_c0.t <= ANG_W'(DEG90)) && (r_c0.t >= -ANG_W'(DEG90)))
    `AARM_ASSERT_IMP(a_never_busy, i_clk, i_rst_n, start, !busy)
endmodule

### tb/tb.sv
// Testbench for axis_angle_rotation_matrix: predicts the nine Q4.14 matrix entries
// from angle and axis, checks every strobed result in order. Depends on aarm_pkg.
`timescale 1ns / 1ps
module tb;
    import aarm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = CORDIC_STEPS + 20;

    typedef struct {
        logic signed [OUT_W-1:0] e [9];
    } t_matrix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_angle_deg = '0;
    logic signed [AXIS_W-1:0] i_axis_x = '0;
    logic signed [AXIS_W-1:0] i_axis_y = '0;
    logic signed [AXIS_W-1:0] i_axis_z = '0;
    logic o_valid;
    logic signed [OUT_W-1:0] o_c0_r0, o_c0_r1, o_c0_r2, o_c1_r0, o_c1_r1, o_c1_r2;
    logic signed [OUT_W-1:0] o_c2_r0, o_c2_r1, o_c2_r2;

    t_matrix expected_matrices [$];
    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_cycles = 0;

    axis_angle_rotation_matrix dut (.*);

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat(longint v);
        longint hi, lo;
        hi = (longint'(1) << (OUT_W - 1)) - 1;
        lo = -(longint'(1) << (OUT_W - 1));
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[OUT_W-1:0];
    endfunction

    // rotation matrix predictor: fold, CORDIC, Rodrigues terms
    function automatic t_matrix rotation_matrix(logic signed [31:0] ang,
            logic signed [AXIS_W-1:0] ux, logic signed [AXIS_W-1:0] uy,
            logic signed [AXIS_W-1:0] uz);
        t_matrix m;
        longint r, t, x, y, nx, ny, cs, sn, a, one, ax, ay, az;
        longint pxx, pyy, pzz, pxy, pxz, pyz;
        bit flip;
        flip = 0;
        r = longint'(ang) % TURN_IN;
        if (r < 0) r += TURN_IN;
        t = r * 256;
        if (t > DEG180) t -= DEG360;
        if (t > DEG90) begin
            t -= DEG180; flip = 1;
        end else if (t < -DEG90) begin
            t += DEG180; flip = 1;
        end
        x = GAIN_START;
        y = 0;
        for (int i = 0; i < N_STEPS; i++) begin
            if (t >= 0) begin
                nx = x - asr(y, i); ny = y + asr(x, i); t -= atan_at(i);
            end else begin
                nx = x + asr(y, i); ny = y - asr(x, i); t += atan_at(i);
            end
            x = nx; y = ny;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        one = longint'(1) << FRAC_BITS;
        cs = rnd(x, VEC_FRAC - FRAC_BITS);
        sn = rnd(y, VEC_FRAC - FRAC_BITS);
        a = one - cs;
        ax = ux; ay = uy; az = uz;
        pxx = rnd(ax * ax, FRAC_BITS); pyy = rnd(ay * ay, FRAC_BITS);
        pzz = rnd(az * az, FRAC_BITS); pxy = rnd(ax * ay, FRAC_BITS);
        pxz = rnd(ax * az, FRAC_BITS); pyz = rnd(ay * az, FRAC_BITS);
        m.e[0] = sat(rnd(cs * one + pxx * a, FRAC_BITS));
        m.e[1] = sat(rnd(pxy * a + az * sn, FRAC_BITS));
        m.e[2] = sat(rnd(pxz * a - ay * sn, FRAC_BITS));
        m.e[3] = sat(rnd(pxy * a - az * sn, FRAC_BITS));
        m.e[4] = sat(rnd(cs * one + pyy * a, FRAC_BITS));
        m.e[5] = sat(rnd(pyz * a + ax * sn, FRAC_BITS));
        m.e[6] = sat(rnd(pxz * a + ay * sn, FRAC_BITS));
        m.e[7] = sat(rnd(pyz * a - ax * sn, FRAC_BITS));
        m.e[8] = sat(rnd(cs * one + pzz * a, FRAC_BITS));
        return m;
    endfunction

    task automatic report_mismatch(string what, int idx, longint got, longint want);
        $display("MISMATCH result %0d %s: got %0d want %0d", idx, what, got, want);
        n_errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_matrix want;
        logic signed [OUT_W-1:0] got [9];
        if (i_rst_n && o_valid) begin
            got = '{o_c0_r0, o_c0_r1, o_c0_r2, o_c1_r0, o_c1_r1, o_c1_r2,
                    o_c2_r0, o_c2_r1, o_c2_r2};
            if (expected_matrices.size() == 0) begin
                report_mismatch("unexpected result", n_checked, 0, 0);
            end else begin
                want = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.e[k])
                        report_mismatch($sformatf("c%0d_r%0d", k / 3, k % 3), n_checked,
                                        got[k], want.e[k]);
            end
            n_checked++;
        end
    end

    // send one item, holding start until accepted
    task automatic send_item(logic signed [31:0] ang, logic signed [AXIS_W-1:0] ux,
            logic signed [AXIS_W-1:0] uy, logic signed [AXIS_W-1:0] uz);
        start <= 1'b1;
        i_angle_deg <= ang;
        i_axis_x <= ux;
        i_axis_y <= uy;
        i_axis_z <= uz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_matrices.push_back(rotation_matrix(ang, ux, uy, uz));
        n_sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // extremes, the fold points, negative angles, large axes
    task automatic test_directed();
        localparam logic signed [AXIS_W-1:0] ONE_Q = 16'sd16384;
        send_item(32'sd0, ONE_Q, 16'sd0, 16'sd0);
        send_item(32'sd23040, 16'sd0, ONE_Q, 16'sd0);
        send_item(32'sd46080, 16'sd0, 16'sd0, ONE_Q);
        send_item(-32'sd46080, 16'sd9459, 16'sd9459, 16'sd9459);
        send_item(32'sd69120, ONE_Q, ONE_Q, ONE_Q);
        send_item(32'sd92160, 16'sd0, 16'sd0, 16'sd0);
        send_item(-32'sd23040, ONE_Q, 16'sd0, 16'sd0);
        send_item(32'sd2147483647, 16'sd32767, 16'sd32767, 16'sd32767);
        send_item(-32'sd2147483648, -16'sd32768, -16'sd32768, -16'sd32768);
        send_item(32'sd1, 16'sd32767, -16'sd32768, 16'sd1);
        send_item(-32'sd1, -16'sd1, 16'sd32767, -16'sd32768);
        send_item(32'sd23041, -16'sd32768, 16'sd32767, 16'sd32767);
        send_item(32'sd46079, 16'sd32767, 16'sd0, -16'sd32768);
        send_item(32'sd46081, -16'sd32768, -16'sd32768, 16'sd0);
        send_item(32'sd69119, 16'sd0, 16'sd32767, 16'sd32767);
        send_item(32'sd92159, -16'sd1, -16'sd1, -16'sd1);
        send_item(-32'sd92160, ONE_Q, ONE_Q, 16'sd0);
        send_item(32'sd11520, 16'sd11585, 16'sd0, 16'sd11585);
        idle_cycles(1);
    endtask

    // random items in bursts with random gaps
    task automatic test_random(int count);
        int left, burst, kind;
        logic signed [31:0] ang;
        logic signed [AXIS_W-1:0] v [3];
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) burst = 1;
            for (int b = 0; b < burst && left > 0; b++) begin
                kind = $urandom_range(0, 3);
                case (kind)
                    0: ang = $urandom;
                    1: ang = $urandom_range(0, 92160 * 2) - 92160;
                    2: ang = 32'sd23040 * $urandom_range(0, 8) - 32'sd92160
                             + $urandom_range(0, 2) - 1;
                    default: ang = $urandom_range(0, 92159);
                endcase
                for (int k = 0; k < 3; k++)
                    v[k] = ($urandom_range(0, 1)) ? AXIS_W'($urandom)
                         : AXIS_W'($urandom_range(0, 32768) - 16384);
                send_item(ang, v[0], v[1], v[2]);
                left--;
            end
            if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 30));
        end
        idle_cycles(1);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1350);
        while (expected_matrices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d items (directed fold points and extremes, random bursts),",
                 n_sent);
        $display("%0d results checked, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/aarm_pkg.sv
rtl/aarm_cell.sv
rtl/aarm_matrix.sv
rtl/axis_angle_rotation_matrix.sv
tb/tb.sv
